>>> rtl/core/ole_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list engine package
// Shared widths, command and status codes, controller states and the control
// bundle that the controller broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package ole_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int VALUE_W        = 32;
	localparam int FUNC_W         = 3;
	localparam int STATUS_W       = 2;

	typedef enum logic [FUNC_W-1:0] {
		F_INS_HEAD = 3'd0,
		F_INS_TAIL = 3'd1,
		F_INS_AT   = 3'd2,
		F_REM_HEAD = 3'd3,
		F_REM_TAIL = 3'd4,
		F_REM_AT   = 3'd5,
		F_SEARCH   = 3'd6,
		F_READ_AT  = 3'd7
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_RANGE    = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_SCAN = 1'b1
	} state_t;

	typedef struct packed {
		logic ins;
		logic rem;
		logic tap_load;
		logic tap_sel_pos;
		logic tap_shift;
	} cell_ctrl_t;

endpackage

>>> rtl/core/ole_cell.sv
// ----------------------------------------------------------------------------
// Ordered list engine storage cell
// Holds one slot of the sequence and one stage of the result scan chain.
// ----------------------------------------------------------------------------
module ole_cell #(
	parameter int DATA_WIDTH = ole_pkg::DATA_WIDTH_DEF,
	parameter int POS_W      = $clog2(ole_pkg::CAPACITY_DEF + 1),
	parameter int IDX        = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ole_pkg::cell_ctrl_t    ctrl,
	input  logic [POS_W-1:0]       pos,
	input  logic [POS_W-1:0]       cnt,
	input  logic [DATA_WIDTH-1:0]  word,
	input  logic [DATA_WIDTH-1:0]  left_data,
	input  logic [DATA_WIDTH-1:0]  right_data,
	input  logic                   right_hit,
	input  logic [DATA_WIDTH-1:0]  right_tap,
	output logic [DATA_WIDTH-1:0]  data,
	output logic                   tap_hit,
	output logic [DATA_WIDTH-1:0]  tap_data
);
	import ole_pkg::*;

	localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

	logic [DATA_WIDTH-1:0] slot_q;
	logic [DATA_WIDTH-1:0] tap_data_q;
	logic                  tap_hit_q;
	logic                  load_hit;

	assign load_hit = ctrl.tap_sel_pos ? (MY_IDX == pos)
	                                   : ((MY_IDX < cnt) && (slot_q == word));

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (MY_IDX == pos) begin
				slot_q <= word;
			end else if (MY_IDX > pos) begin
				slot_q <= left_data;
			end
		end else if (ctrl.rem && (MY_IDX >= pos)) begin
			slot_q <= right_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_hit_q <= 1'b0;
		end else if (ctrl.tap_load) begin
			tap_hit_q <= load_hit;
		end else if (ctrl.tap_shift) begin
			tap_hit_q <= right_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.tap_load) begin
			tap_data_q <= slot_q;
		end else if (ctrl.tap_shift) begin
			tap_data_q <= right_tap;
		end
	end

	assign data     = slot_q;
	assign tap_hit  = tap_hit_q;
	assign tap_data = tap_data_q;

endmodule

>>> rtl/core/ole_ctrl.sv
// ----------------------------------------------------------------------------
// Ordered list engine controller
// Decodes commands, keeps the word count, drives the cell chain and gathers
// scan results into the output register.
// ----------------------------------------------------------------------------
module ole_ctrl #(
	parameter int CAPACITY   = ole_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = ole_pkg::DATA_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [ole_pkg::FUNC_W-1:0]            func,
	input  logic signed [ole_pkg::VALUE_W-1:0]    value,
	input  logic [$clog2(CAPACITY+1)-1:0]         position,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [ole_pkg::VALUE_W-1:0]    result_value,
	output logic [$clog2(CAPACITY)-1:0]           found_index,
	output logic [ole_pkg::STATUS_W-1:0]          status,
	output logic [$clog2(CAPACITY+1)-1:0]         count,
	output logic                                  is_empty,
	output ole_pkg::cell_ctrl_t                   ctrl,
	output logic [$clog2(CAPACITY+1)-1:0]         cell_pos,
	output logic [$clog2(CAPACITY+1)-1:0]         cell_cnt,
	output logic [DATA_WIDTH-1:0]                 cell_word,
	input  logic                                  tap_hit0,
	input  logic [DATA_WIDTH-1:0]                 tap_data0
);
	import ole_pkg::*;

	localparam int POS_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam logic [POS_W-1:0] CAP_V = POS_W'(CAPACITY);
	localparam logic [POS_W-1:0] ONE   = POS_W'(1);

	state_t state_q, state_d;

	logic [POS_W-1:0] count_q;
	logic [POS_W-1:0] idx_q;
	logic [POS_W-1:0] limit_q;
	logic [POS_W-1:0] pcount_q;
	logic             search_q;

	logic                       out_valid_q;
	logic signed [VALUE_W-1:0]  result_value_q;
	logic [IDX_W-1:0]           found_index_q;
	status_t                    status_q;
	logic [POS_W-1:0]           count_out_q;

	func_t            f;
	status_t          d_status;
	logic             d_ins, d_rem, d_scan, d_sel_pos;
	logic [POS_W-1:0] d_pos, d_count;

	logic out_free, accept, scan_end, scan_done;

	assign f         = func_t'(func);
	assign out_free  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign scan_end  = tap_hit0 || (idx_q == limit_q);
	assign scan_done = (state_q == S_SCAN) && scan_end && out_free;

	always_comb begin
		d_status  = ST_OK;
		d_ins     = 1'b0;
		d_rem     = 1'b0;
		d_scan    = 1'b0;
		d_sel_pos = 1'b1;
		d_pos     = position;
		d_count   = count_q;
		unique case (f) inside
			F_INS_HEAD, F_INS_TAIL: begin
				d_pos = (f == F_INS_HEAD) ? '0 : count_q;
				if (count_q == CAP_V) begin
					d_status = ST_FULL;
				end else begin
					d_ins   = 1'b1;
					d_count = count_q + ONE;
				end
			end
			F_INS_AT: begin
				if (position > count_q) begin
					d_status = ST_RANGE;
				end else if (count_q == CAP_V) begin
					d_status = ST_FULL;
				end else begin
					d_ins   = 1'b1;
					d_count = count_q + ONE;
				end
			end
			F_REM_HEAD, F_REM_TAIL: begin
				d_pos = (f == F_REM_HEAD) ? '0 : count_q - ONE;
				if (count_q == '0) begin
					d_status = ST_RANGE;
				end else begin
					d_rem   = 1'b1;
					d_scan  = 1'b1;
					d_count = count_q - ONE;
				end
			end
			F_REM_AT: begin
				if (position >= count_q) begin
					d_status = ST_RANGE;
				end else begin
					d_rem   = 1'b1;
					d_scan  = 1'b1;
					d_count = count_q - ONE;
				end
			end
			F_SEARCH: begin
				d_scan    = 1'b1;
				d_sel_pos = 1'b0;
			end
			F_READ_AT: begin
				if (position >= count_q) begin
					d_status = ST_RANGE;
				end else begin
					d_scan = 1'b1;
				end
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && d_scan) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_done) begin
					state_d = S_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		in_ready         = (state_q == S_IDLE) && out_free;
		ctrl.ins         = accept && d_ins;
		ctrl.rem         = accept && d_rem;
		ctrl.tap_load    = accept && d_scan;
		ctrl.tap_sel_pos = d_sel_pos;
		ctrl.tap_shift   = (state_q == S_SCAN) && !scan_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				count_q <= d_count;
			end
			if ((accept && !d_scan) || scan_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q    <= '0;
			limit_q  <= count_q;
			pcount_q <= d_count;
			search_q <= !d_sel_pos;
		end else if (ctrl.tap_shift) begin
			idx_q <= idx_q + ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !d_scan) begin
			result_value_q <= '0;
			found_index_q  <= '0;
			status_q       <= d_status;
			count_out_q    <= d_count;
		end else if (scan_done) begin
			result_value_q <= search_q ? '0 : VALUE_W'($signed(tap_data0));
			found_index_q  <= (search_q && tap_hit0) ? idx_q[IDX_W-1:0] : '0;
			status_q       <= tap_hit0 ? ST_OK : ST_NOTFOUND;
			count_out_q    <= pcount_q;
		end
	end

	assign cell_pos     = d_pos;
	assign cell_cnt     = count_q;
	assign cell_word    = DATA_WIDTH'(value);
	assign out_valid    = out_valid_q;
	assign result_value = result_value_q;
	assign found_index  = found_index_q;
	assign status       = status_q;
	assign count        = count_out_q;
	assign is_empty     = (count_out_q == '0);

endmodule

>>> rtl/core/ordered_list_engine_unit.sv
// ----------------------------------------------------------------------------
// Ordered list engine
// A bounded ordered sequence of signed words with insert, remove, search and
// read at the head, the tail or any position.
//
// Commands enter on the in channel (func, value, position) and each gives
// exactly one item on the out channel (result_value, found_index, status,
// count, is_empty); both channels use valid and ready.
// Every slot is a cell in a chain, so inserts and removes shift the slots at
// and behind the position in the cycle that the command is accepted. Insert
// commands and refused commands put their result in the output register in
// the cycle after acceptance. Read, remove and search commands load a scan
// chain of the cells and shift it toward the head one cell per cycle; a
// search ends at the first match, or at the end of the stored words when no
// word matches.
// The next command is taken once the previous result has been loaded and the
// output register is free or being emptied. When the receiver stalls, the
// finished result stays in the output register and a scan waits at its end.
// Reset empties the sequence and drops any pending result; slot contents are
// not cleared.
// ----------------------------------------------------------------------------
module ordered_list_engine_unit #(
	parameter int CAPACITY   = ole_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = ole_pkg::DATA_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [ole_pkg::FUNC_W-1:0]            func,
	input  logic signed [ole_pkg::VALUE_W-1:0]    value,
	input  logic [$clog2(CAPACITY+1)-1:0]         position,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [ole_pkg::VALUE_W-1:0]    result_value,
	output logic [$clog2(CAPACITY)-1:0]           found_index,
	output logic [ole_pkg::STATUS_W-1:0]          status,
	output logic [$clog2(CAPACITY+1)-1:0]         count,
	output logic                                  is_empty
);
	import ole_pkg::*;

	localparam int POS_W = $clog2(CAPACITY + 1);

	cell_ctrl_t            ctrl;
	logic [POS_W-1:0]      cell_pos;
	logic [POS_W-1:0]      cell_cnt;
	logic [DATA_WIDTH-1:0] cell_word;

	logic [DATA_WIDTH-1:0] slot_data [CAPACITY];
	logic                  tap_hit   [CAPACITY];
	logic [DATA_WIDTH-1:0] tap_data  [CAPACITY];

	ole_ctrl #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.value        (value),
		.position     (position),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.found_index  (found_index),
		.status       (status),
		.count        (count),
		.is_empty     (is_empty),
		.ctrl         (ctrl),
		.cell_pos     (cell_pos),
		.cell_cnt     (cell_cnt),
		.cell_word    (cell_word),
		.tap_hit0     (tap_hit[0]),
		.tap_data0    (tap_data[0])
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_data;
		logic [DATA_WIDTH-1:0] right_data;
		logic                  right_hit;
		logic [DATA_WIDTH-1:0] right_tap;

		if (i == 0) begin : g_head
			assign left_data = cell_word;
		end else begin : g_body
			assign left_data = slot_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_data = '0;
			assign right_hit  = 1'b0;
			assign right_tap  = '0;
		end else begin : g_link
			assign right_data = slot_data[i+1];
			assign right_hit  = tap_hit[i+1];
			assign right_tap  = tap_data[i+1];
		end

		ole_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.POS_W      (POS_W),
			.IDX        (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.pos        (cell_pos),
			.cnt        (cell_cnt),
			.word       (cell_word),
			.left_data  (left_data),
			.right_data (right_data),
			.right_hit  (right_hit),
			.right_tap  (right_tap),
			.data       (slot_data[i]),
			.tap_hit    (tap_hit[i]),
			.tap_data   (tap_data[i])
		);
	end

endmodule

>>> tb/ordered_list_engine_unit_tb.sv
// ----------------------------------------------------------------------------
// Ordered list engine testbench
// Drives insert, remove, search and read commands into the list engine and
// checks every result against a behavioral copy of the list kept in the
// testbench. Directed cases cover the empty and the full store, range errors
// and extreme words; random traffic follows with random gaps on both sides,
// a back-to-back burst and a long output hold-off.
// ----------------------------------------------------------------------------
module ordered_list_engine_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import ole_pkg::*;

	localparam int DEPTH       = CAPACITY_DEF;
	localparam int QUIET_LIMIT = 1000;
	localparam int HOLD_CYCLES = 200;

	typedef struct {
		logic signed [VALUE_W-1:0] word;
		logic [5:0]                index;
		status_t                   st;
		logic [6:0]                held;
		logic                      empty;
	} list_result_t;

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      in_valid  = 1'b0;
	logic                      in_ready;
	logic [FUNC_W-1:0]         func      = '0;
	logic signed [VALUE_W-1:0] value     = '0;
	logic [6:0]                position  = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic signed [VALUE_W-1:0] result_value;
	logic [5:0]                found_index;
	logic [STATUS_W-1:0]       status;
	logic [6:0]                count;
	logic                      is_empty;

	logic signed [VALUE_W-1:0] list_words [DEPTH];
	int                        list_len = 0;
	list_result_t              pending_results [$];
	int                        mismatches  = 0;
	int                        quiet_count = 0;
	int                        hold_left   = 0;
	int                        stall_left  = 0;
	bit                        tx_idle     = 1'b1;
	bit                        rx_idle     = 1'b1;

	ordered_list_engine_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.value        (value),
		.position     (position),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.found_index  (found_index),
		.status       (status),
		.count        (count),
		.is_empty     (is_empty)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic void list_insert(int pos, logic signed [VALUE_W-1:0] word);
		for (int i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
		list_words[pos] = word;
		list_len++;
	endfunction

	function automatic logic signed [VALUE_W-1:0] list_remove(int pos);
		logic signed [VALUE_W-1:0] word;
		word = list_words[pos];
		for (int i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
		list_len--;
		return word;
	endfunction

	function automatic list_result_t apply_command(func_t f, logic signed [VALUE_W-1:0] v,
			int p);
		list_result_t r;
		r.word  = '0;
		r.index = '0;
		r.st    = ST_OK;
		case (f)
			F_INS_HEAD, F_INS_TAIL: begin
				if (list_len >= DEPTH) r.st = ST_FULL;
				else list_insert((f == F_INS_HEAD) ? 0 : list_len, v);
			end
			F_INS_AT: begin
				if (p > list_len) r.st = ST_RANGE;
				else if (list_len >= DEPTH) r.st = ST_FULL;
				else list_insert(p, v);
			end
			F_REM_HEAD, F_REM_TAIL: begin
				if (list_len == 0) r.st = ST_RANGE;
				else r.word = list_remove((f == F_REM_HEAD) ? 0 : list_len - 1);
			end
			F_REM_AT: begin
				if (p >= list_len) r.st = ST_RANGE;
				else r.word = list_remove(p);
			end
			F_SEARCH: begin
				r.st = ST_NOTFOUND;
				for (int i = 0; i < list_len; i++) begin
					if (list_words[i] == v) begin
						r.index = 6'(i);
						r.st    = ST_OK;
						break;
					end
				end
			end
			default: begin
				if (p >= list_len) r.st = ST_RANGE;
				else r.word = list_words[p];
			end
		endcase
		r.held  = 7'(list_len);
		r.empty = (list_len == 0);
		return r;
	endfunction

	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom_range(0, 15) - 8;
			4: return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_cmd(func_t f, logic signed [VALUE_W-1:0] v, int p);
		int gap;
		gap = tx_idle ? $urandom_range(0, 9) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		value    <= v;
		position <= p[6:0];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_results.push_back(apply_command(f, v, p));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic run_random(int n, int ins_w, int rem_w);
		int                        r;
		int                        p;
		func_t                     f;
		logic signed [VALUE_W-1:0] v;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < ins_w) f = func_t'($urandom_range(0, 2));
			else if (r < ins_w + rem_w) f = func_t'($urandom_range(3, 5));
			else f = $urandom_range(0, 1) ? F_SEARCH : F_READ_AT;
			if (f == F_SEARCH && list_len > 0 && $urandom_range(0, 2) != 0)
				v = list_words[$urandom_range(0, list_len - 1)];
			else
				v = pick_value();
			p = ($urandom_range(0, 4) == 0) ? $urandom_range(0, DEPTH) :
				$urandom_range(0, list_len);
			send_cmd(f, v, p);
		end
	endtask

	task automatic test_empty_store();
		send_cmd(F_REM_HEAD, 0, 0);
		send_cmd(F_REM_TAIL, -1, 0);
		send_cmd(F_REM_AT, 0, 0);
		send_cmd(F_READ_AT, 0, 0);
		send_cmd(F_SEARCH, 0, 0);
		send_cmd(F_INS_AT, 5, 1);
		send_cmd(F_INS_AT, 5, DEPTH);
		send_cmd(F_READ_AT, 0, DEPTH);
		wait_drained();
	endtask

	task automatic test_directed_extremes();
		send_cmd(F_INS_HEAD, 32'sh8000_0000, 0);
		send_cmd(F_INS_TAIL, 32'sh7fff_ffff, 0);
		send_cmd(F_INS_AT, -1, 1);
		send_cmd(F_INS_AT, 0, 3);
		send_cmd(F_INS_AT, 7, 5);
		send_cmd(F_SEARCH, -1, 0);
		send_cmd(F_SEARCH, 32'sh7fff_ffff, 0);
		send_cmd(F_SEARCH, 12345, 0);
		send_cmd(F_READ_AT, 0, 0);
		send_cmd(F_READ_AT, 0, 3);
		send_cmd(F_READ_AT, 0, 4);
		send_cmd(F_REM_AT, 0, 1);
		send_cmd(F_REM_AT, 0, 4);
		send_cmd(F_REM_TAIL, 0, 0);
		send_cmd(F_REM_HEAD, 0, 0);
		send_cmd(F_REM_HEAD, 0, 0);
		send_cmd(F_REM_HEAD, 0, 0);
		wait_drained();
	endtask

	task automatic test_fill_to_capacity();
		while (list_len < DEPTH)
			send_cmd(func_t'($urandom_range(0, 2)), pick_value(),
				$urandom_range(0, list_len));
		send_cmd(F_INS_HEAD, 1, 0);
		send_cmd(F_INS_TAIL, 1, 0);
		send_cmd(F_INS_AT, 1, 0);
		send_cmd(F_INS_AT, 1, DEPTH);
		send_cmd(F_READ_AT, 0, DEPTH - 1);
		send_cmd(F_READ_AT, 0, DEPTH);
		send_cmd(F_SEARCH, list_words[DEPTH-1], 0);
		send_cmd(F_REM_AT, 0, DEPTH - 1);
		send_cmd(F_INS_AT, 32'sh7fff_ffff, DEPTH - 1);
		while (list_len > 0)
			send_cmd(func_t'($urandom_range(3, 5)), pick_value(),
				$urandom_range(0, list_len - 1));
		send_cmd(F_REM_AT, 0, 0);
		wait_drained();
	endtask

	task automatic test_back_to_back();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		run_random(100, 40, 35);
		wait_drained();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	task automatic test_output_hold_off();
		tx_idle   = 1'b0;
		hold_left = HOLD_CYCLES;
		run_random(40, 40, 30);
		wait_drained();
		tx_idle = 1'b1;
	endtask

	task automatic test_random_mix();
		run_random(200, 60, 20);
		wait_drained();
		run_random(300, 35, 35);
		run_random(200, 15, 60);
		wait_drained();
		run_random(250, 55, 25);
		run_random(150, 30, 40);
		wait_drained();
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		list_result_t e;
		if (arst_n && out_valid && out_ready) begin
			stall_left = rx_idle ? $urandom_range(0, 9) : 0;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: value %0d index %0d status %0d count %0d",
						result_value, found_index, status, count);
			end else begin
				e = pending_results.pop_front();
				if (result_value !== e.word || found_index !== e.index ||
						status !== e.st || count !== e.held || is_empty !== e.empty) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected value %0d index %0d status %s count %0d ",
							"empty %0b, got value %0d index %0d status %0d count %0d ",
							"empty %0b"}, e.word, e.index, e.st.name(), e.held, e.empty,
							result_value, found_index, status, count, is_empty);
				end
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_count = 0;
		else quiet_count++;
		if (quiet_count >= QUIET_LIMIT) begin
			$display("ordered_list_engine_unit test failed");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_empty_store();
		test_directed_extremes();
		test_fill_to_capacity();
		test_back_to_back();
		test_output_hold_off();
		test_random_mix();
		wait_drained();
		repeat (80) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("ordered_list_engine_unit test passed");
		else
			$display("ordered_list_engine_unit test failed");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/ole_pkg.sv
rtl/core/ole_cell.sv
rtl/core/ole_ctrl.sv
rtl/core/ordered_list_engine_unit.sv
tb/ordered_list_engine_unit_tb.sv
